/* rtl/infix_precedence_accumulator_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the infix precedence accumulator
// Concurrent checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INFIX_PRECEDENCE_ACCUMULATOR_ASSERT_SVH
`define INFIX_PRECEDENCE_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define IPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define IPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/ipa_pkg.sv */
// ----------------------------------------------------------------------------
// ipa_pkg
// Types and constants shared by the accumulator sequencer and its ALU.
// ----------------------------------------------------------------------------
package ipa_pkg;

  localparam int DATA_W          = 64;
  localparam int VALUE_WIDTH_DEF = 64;
  localparam int FRAC_BITS_DEF   = 32;

  // operator codes; OP_NONE marks an empty operator slot
  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MOD  = 3'd4,
    OP_END  = 3'd5,
    OP_NONE = 3'd7
  } op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] operand;
    logic [2:0]               opcode;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic                     zero_divide;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY1,
    S_APPLY2,
    S_FINISH
  } seq_state_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_FIX,
    A_DONE
  } alu_state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_ctl_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_sts_t;

endpackage

/* rtl/ipa_alu.sv */
// ----------------------------------------------------------------------------
// ipa_alu
// Shared fixed-point unit: saturating add/sub in one step, shift-add
// multiply over W steps, restoring divide/modulo over W+F steps.
// ----------------------------------------------------------------------------
module ipa_alu #(
  parameter int W = ipa_pkg::VALUE_WIDTH_DEF,
  parameter int F = ipa_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ipa_pkg::alu_ctl_t   ctl,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output ipa_pkg::alu_sts_t   sts,
  output logic signed [W-1:0] res
);

  localparam int NW   = W + F;
  localparam int MAGW = (2 * W > NW) ? 2 * W : NW;
  localparam int CW   = $clog2(NW + 1);
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [MAGW-1:0] LIM = MAGW'(1) << (W - 1);

  ipa_pkg::alu_state_t st_r, st_nxt;
  ipa_pkg::op_t        op_r, op_nxt;
  logic                neg_r, neg_nxt;
  logic [W-1:0]        x_r, x_nxt;
  logic [2*W-1:0]      p_r, p_nxt;
  logic [W-1:0]        d_r, d_nxt;
  logic [NW-1:0]       n_r, n_nxt;
  logic [W-2:0]        rem_r, rem_nxt;
  logic [MAGW-1:0]     mag_r, mag_nxt;
  logic [W-1:0]        res_r, res_nxt;
  logic                dz_r, dz_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;

  logic [W-1:0] mag_a, mag_b;
  logic [W:0]   sum;
  logic [W:0]   macc;
  logic [W-1:0] trial;
  logic [W:0]   diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ipa_pkg::A_IDLE;
      dz_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      dz_r <= dz_nxt;
    end
    op_r  <= op_nxt;
    neg_r <= neg_nxt;
    x_r   <= x_nxt;
    p_r   <= p_nxt;
    d_r   <= d_nxt;
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    mag_r <= mag_nxt;
    res_r <= res_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    mag_a = a[W-1] ? W'(-a) : W'(a);
    mag_b = b[W-1] ? W'(-b) : W'(b);
    // exact sum or difference, one bit wider
    if (ctl.op == ipa_pkg::OP_SUB) begin
      sum = {a[W-1], a} - {b[W-1], b};
    end else begin
      sum = {a[W-1], a} + {b[W-1], b};
    end
    // multiply step: add multiplicand into the upper half
    macc  = {1'b0, p_r[2*W-1:W]} + (p_r[0] ? {1'b0, x_r} : {(W+1){1'b0}});
    // divide step: trial subtract
    trial = {rem_r, n_r[NW-1]};
    diff  = {1'b0, trial} - {1'b0, d_r};
  end

  always_comb begin
    st_nxt  = st_r;
    op_nxt  = op_r;
    neg_nxt = neg_r;
    x_nxt   = x_r;
    p_nxt   = p_r;
    d_nxt   = d_r;
    n_nxt   = n_r;
    rem_nxt = rem_r;
    mag_nxt = mag_r;
    res_nxt = res_r;
    dz_nxt  = dz_r;
    cnt_nxt = cnt_r;
    sts.done     = 1'b0;
    sts.div_zero = dz_r;

    unique case (st_r)
      ipa_pkg::A_IDLE: begin
        st_nxt = ipa_pkg::A_IDLE;
      end
      ipa_pkg::A_MUL: begin
        p_nxt   = {macc, p_r[W-1:1]};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          st_nxt = ipa_pkg::A_FIX;
        end
      end
      ipa_pkg::A_DIV: begin
        if (!diff[W]) begin
          rem_nxt = diff[W-2:0];
        end else begin
          rem_nxt = trial[W-2:0];
        end
        n_nxt   = {n_r[NW-2:0], ~diff[W]};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          st_nxt = ipa_pkg::A_FIX;
        end
      end
      ipa_pkg::A_FIX: begin
        // pick magnitude, then saturate into W bits
        if (op_r == ipa_pkg::OP_MUL) begin
          mag_nxt = MAGW'(p_r >> F);
        end else if (op_r == ipa_pkg::OP_DIV) begin
          mag_nxt = MAGW'(n_r);
        end else begin
          mag_nxt = MAGW'(rem_r);
        end
        st_nxt = ipa_pkg::A_DONE;
        if (neg_r) begin
          res_nxt = (mag_nxt > LIM) ? VMIN : W'(-mag_nxt[W-1:0]);
        end else begin
          res_nxt = (mag_nxt >= LIM) ? VMAX : mag_nxt[W-1:0];
        end
      end
      ipa_pkg::A_DONE: begin
        sts.done = 1'b1;
        st_nxt   = ipa_pkg::A_IDLE;
      end
      default: begin
        st_nxt = ipa_pkg::A_IDLE;
      end
    endcase

    // a new operation starts from idle or right on the done cycle
    if (ctl.start && (st_r == ipa_pkg::A_IDLE || st_r == ipa_pkg::A_DONE)) begin
      op_nxt = ctl.op;
      dz_nxt = 1'b0;
      case (ctl.op)
        ipa_pkg::OP_ADD, ipa_pkg::OP_SUB: begin
          res_nxt = (sum[W] != sum[W-1]) ? (sum[W] ? VMIN : VMAX) : sum[W-1:0];
          st_nxt  = ipa_pkg::A_DONE;
        end
        ipa_pkg::OP_MUL: begin
          neg_nxt = a[W-1] ^ b[W-1];
          x_nxt   = mag_a;
          p_nxt   = {{W{1'b0}}, mag_b};
          cnt_nxt = CW'(W);
          st_nxt  = ipa_pkg::A_MUL;
        end
        ipa_pkg::OP_DIV, ipa_pkg::OP_MOD: begin
          neg_nxt = (ctl.op == ipa_pkg::OP_DIV) ? (a[W-1] ^ b[W-1]) : a[W-1];
          d_nxt   = mag_b;
          rem_nxt = '0;
          n_nxt   = NW'(mag_a) << ((ctl.op == ipa_pkg::OP_DIV) ? F : 0);
          cnt_nxt = CW'(NW);
          if (mag_b == '0) begin
            // zero divisor: result 0, raise the flag
            res_nxt = '0;
            dz_nxt  = 1'b1;
            st_nxt  = ipa_pkg::A_DONE;
          end else begin
            st_nxt = ipa_pkg::A_DIV;
          end
        end
        default: begin
          res_nxt = '0;
          st_nxt  = ipa_pkg::A_DONE;
        end
      endcase
    end
  end

  assign res = res_r;

endmodule

/* rtl/infix_precedence_accumulator.sv */
// ----------------------------------------------------------------------------
// infix_precedence_accumulator
// Two-level precedence infix evaluator over a stream of operand/operator
// items, saturating signed fixed point, one shared iterative ALU.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | in_data  (operand, opcode)
//  out_    | output    | out_valid / out_ready | out_data (result, zero_divide)
//
// An item runs zero, one or two ALU operations; ready is low meanwhile.
// Add/sub run in one ALU step; multiply and divide/modulo (Q32.32 by default)
// iterate in the radix-2 loop of the shared ALU; an item costs up to two ALU operations.
// Reset (rst_n low, synchronous) empties the expression and the result slot.
// An end item waits until the result register is free; out_ready stalls
// back-pressure only that final load.
// ----------------------------------------------------------------------------
module infix_precedence_accumulator #(
  parameter int VALUE_WIDTH = ipa_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = ipa_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ipa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ipa_pkg::out_item_t out_data
);

  `include "infix_precedence_accumulator_assert.svh"

  localparam int W  = VALUE_WIDTH;
  localparam int DW = ipa_pkg::DATA_W;
  localparam logic signed [DW-1:0] VMAX = (DW'(1) <<< (W - 1)) - DW'(1);
  localparam logic signed [DW-1:0] VMIN = -VMAX - DW'(1);

  ipa_pkg::seq_state_t state_r, state_nxt;
  logic signed [W-1:0] run_r, run_nxt;
  logic signed [W-1:0] held_r, held_nxt;
  ipa_pkg::op_t        pend_r, pend_nxt;
  ipa_pkg::op_t        hop_r, hop_nxt;
  ipa_pkg::op_t        nop_r, nop_nxt;
  logic                end_r, end_nxt;
  logic                err_r, err_nxt;
  logic                out_valid_r, out_valid_nxt;
  ipa_pkg::out_item_t  out_data_r, out_data_nxt;

  ipa_pkg::alu_ctl_t   alu_ctl;
  ipa_pkg::alu_sts_t   alu_sts;
  logic signed [W-1:0] alu_a, alu_b, alu_res;

  ipa_pkg::op_t        in_op, op_eff;
  logic signed [W-1:0] v_sat;
  logic                in_fire, is_end;

  ipa_alu #(.W(W), .F(FRAC_BITS)) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .a     (alu_a),
    .b     (alu_b),
    .sts   (alu_sts),
    .res   (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipa_pkg::S_IDLE;
      run_r       <= '0;
      held_r      <= '0;
      pend_r      <= ipa_pkg::OP_NONE;
      hop_r       <= ipa_pkg::OP_NONE;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      held_r      <= held_nxt;
      pend_r      <= pend_nxt;
      hop_r       <= hop_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    nop_r      <= nop_nxt;
    end_r      <= end_nxt;
    out_data_r <= out_data_nxt;
  end

  // operand clamp to the value range, opcode decode
  always_comb begin
    in_op = ipa_pkg::op_t'(in_data.opcode);
    if (in_data.operand > VMAX) begin
      v_sat = VMAX[W-1:0];
    end else if (in_data.operand < VMIN) begin
      v_sat = VMIN[W-1:0];
    end else begin
      v_sat = in_data.operand[W-1:0];
    end
    is_end = (in_op == ipa_pkg::OP_END);
    op_eff = is_end ? ipa_pkg::OP_ADD : in_op;
  end

  assign in_ready = (state_r == ipa_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready && (in_data.opcode <= 3'(ipa_pkg::OP_END));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    run_nxt       = run_r;
    held_nxt      = held_r;
    pend_nxt      = pend_r;
    hop_nxt       = hop_r;
    nop_nxt       = nop_r;
    end_nxt       = end_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    alu_ctl.start = 1'b0;
    alu_ctl.op    = pend_r;
    alu_a         = run_r;
    alu_b         = v_sat;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ipa_pkg::S_IDLE: begin
        if (in_fire) begin
          nop_nxt = op_eff;
          end_nxt = is_end;
          if (pend_r == ipa_pkg::OP_NONE) begin
            run_nxt   = v_sat;
            pend_nxt  = op_eff;
            state_nxt = is_end ? ipa_pkg::S_FINISH : ipa_pkg::S_IDLE;
          end else if (op_eff == ipa_pkg::OP_ADD || op_eff == ipa_pkg::OP_SUB ||
                       pend_r == ipa_pkg::OP_MUL || pend_r == ipa_pkg::OP_DIV ||
                       pend_r == ipa_pkg::OP_MOD || hop_r != ipa_pkg::OP_NONE) begin
            alu_ctl.start = 1'b1;
            state_nxt     = ipa_pkg::S_APPLY1;
          end else begin
            // start a multiplicative chain, park the additive left side
            held_nxt = run_r;
            hop_nxt  = pend_r;
            run_nxt  = v_sat;
            pend_nxt = op_eff;
          end
        end
      end
      ipa_pkg::S_APPLY1: begin
        alu_ctl.op = hop_r;
        alu_a      = held_r;
        alu_b      = alu_res;
        if (alu_sts.done) begin
          run_nxt  = alu_res;
          pend_nxt = nop_r;
          err_nxt  = err_r | alu_sts.div_zero;
          if ((nop_r == ipa_pkg::OP_ADD || nop_r == ipa_pkg::OP_SUB) &&
              hop_r != ipa_pkg::OP_NONE) begin
            alu_ctl.start = 1'b1;
            state_nxt     = ipa_pkg::S_APPLY2;
          end else begin
            state_nxt = end_r ? ipa_pkg::S_FINISH : ipa_pkg::S_IDLE;
          end
        end
      end
      ipa_pkg::S_APPLY2: begin
        alu_ctl.op = hop_r;
        alu_a      = held_r;
        alu_b      = alu_res;
        if (alu_sts.done) begin
          run_nxt   = alu_res;
          hop_nxt   = ipa_pkg::OP_NONE;
          err_nxt   = err_r | alu_sts.div_zero;
          state_nxt = end_r ? ipa_pkg::S_FINISH : ipa_pkg::S_IDLE;
        end
      end
      ipa_pkg::S_FINISH: begin
        // load the result slot once free, then clear the expression
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.result      = DW'(run_r);
          out_data_nxt.zero_divide = err_r;
          run_nxt   = '0;
          held_nxt  = '0;
          pend_nxt  = ipa_pkg::OP_NONE;
          hop_nxt   = ipa_pkg::OP_NONE;
          err_nxt   = 1'b0;
          state_nxt = ipa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ipa_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ALU results only arrive while an operation is outstanding
  `IPA_ASSERT_IMP(a_done_in_apply, alu_sts.done,
                  state_r == ipa_pkg::S_APPLY1 || state_r == ipa_pkg::S_APPLY2)
  // a held operator always has a pending one behind it
  `IPA_ASSERT_IMP(a_held_has_pend, hop_r != ipa_pkg::OP_NONE, pend_r != ipa_pkg::OP_NONE)
  // second operation only applies a held operator
  `IPA_ASSERT_IMP(a_apply2_held, state_r == ipa_pkg::S_APPLY2, hop_r != ipa_pkg::OP_NONE)
  // finishing with a free slot presents a result next cycle
  `IPA_ASSERT_NXT(a_finish_loads, state_r == ipa_pkg::S_FINISH && (!out_valid_r || out_ready),
                  out_valid && state_r == ipa_pkg::S_IDLE)

endmodule

/* dv/infix_precedence_accumulator_tb.sv */
// ----------------------------------------------------------------------------
// infix_precedence_accumulator_tb
// Streams infix expressions (operand/operator items) into the evaluator and
// checks every end-of-expression result against a behavioral evaluator with
// saturating Q32.32 arithmetic, under random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module infix_precedence_accumulator_tb;

  localparam int VW = 64;
  localparam int FB = 32;
  localparam int WDOG_LIMIT = 40000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  ipa_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  ipa_pkg::out_item_t out_data;

  infix_precedence_accumulator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // evaluator state
  logic [63:0]  run_val, hold_val;
  ipa_pkg::op_t pend_op, hold_op;
  logic         div_err;

  ipa_pkg::in_item_t  item_q[$];
  ipa_pkg::out_item_t result_q[$];
  int        n_fail, n_sent, n_results, n_zdiv;
  bit        stim_done;
  int        idle_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- fixed-point evaluator ----------------
  function automatic logic [63:0] sat_val(bit neg, logic [127:0] mag);
    logic [127:0] lim;
    lim = 128'd1 << (VW - 1);
    if (neg) begin
      if (mag > lim) mag = lim;
      return 64'd0 - mag[63:0];
    end
    if (mag > lim - 1) mag = lim - 1;
    return mag[63:0];
  endfunction

  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic [63:0] fx_calc(logic [63:0] a, ipa_pkg::op_t op,
                                          logic [63:0] b);
    logic signed [64:0] s;
    logic [127:0] p, n;
    case (op)
      ipa_pkg::OP_ADD, ipa_pkg::OP_SUB: begin
        s = (op == ipa_pkg::OP_ADD) ? ($signed({a[63], a}) + $signed({b[63], b}))
                                    : ($signed({a[63], a}) - $signed({b[63], b}));
        return sat_val(s[64], s[64] ? 128'(-s) : 128'(s));
      end
      ipa_pkg::OP_MUL: begin
        p = (128'(mag64(a)) * 128'(mag64(b))) >> FB;
        return sat_val(a[63] ^ b[63], p);
      end
      ipa_pkg::OP_DIV: begin
        if (mag64(b) == 0) begin
          div_err = 1'b1;
          return 64'd0;
        end
        n = 128'(mag64(a)) << FB;
        return sat_val(a[63] ^ b[63], n / 128'(mag64(b)));
      end
      ipa_pkg::OP_MOD: begin
        if (mag64(b) == 0) begin
          div_err = 1'b1;
          return 64'd0;
        end
        return sat_val(a[63], 128'(mag64(a) % mag64(b)));
      end
      default: return 64'd0;
    endcase
  endfunction

  function automatic bit is_mul_op(ipa_pkg::op_t op);
    return op == ipa_pkg::OP_MUL || op == ipa_pkg::OP_DIV || op == ipa_pkg::OP_MOD;
  endfunction

  task automatic take_operand(logic [63:0] v, ipa_pkg::op_t op);
    if (pend_op == ipa_pkg::OP_NONE) begin
      run_val = v;
      pend_op = op;
    end else if (op == ipa_pkg::OP_ADD || op == ipa_pkg::OP_SUB) begin
      run_val = fx_calc(run_val, pend_op, v);
      pend_op = op;
      if (hold_op != ipa_pkg::OP_NONE) begin
        // deferred low-precedence op: left side is the held value
        run_val = fx_calc(hold_val, hold_op, run_val);
        hold_op = ipa_pkg::OP_NONE;
      end
    end else if (is_mul_op(pend_op) || hold_op != ipa_pkg::OP_NONE) begin
      run_val = fx_calc(run_val, pend_op, v);
      pend_op = op;
    end else begin
      hold_val = run_val;
      hold_op  = pend_op;
      run_val  = v;
      pend_op  = op;
    end
  endtask

  task automatic clear_expr();
    run_val = '0; hold_val = '0; pend_op = ipa_pkg::OP_NONE; hold_op = ipa_pkg::OP_NONE;
    div_err = 1'b0;
  endtask

  task automatic predict_item(ipa_pkg::in_item_t it);
    ipa_pkg::out_item_t r;
    if (it.opcode > 3'(ipa_pkg::OP_END)) return;   // unused opcodes are ignored
    if (it.opcode != 3'(ipa_pkg::OP_END)) begin
      take_operand(it.operand, ipa_pkg::op_t'(it.opcode));
      return;
    end
    take_operand(it.operand, ipa_pkg::OP_ADD);
    r.result = run_val;
    r.zero_divide = div_err;
    result_q.insert(result_q.size(), r);
    clear_expr();
  endtask

  // ---------------- stimulus ----------------
  function automatic logic [63:0] rand_operand();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return {$urandom, $urandom};
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'd0;
      4, 5: return 64'(signed'(int'($urandom_range(0, 40)) - 20)) << FB;
      6: return {{32{1'b0}}, $urandom};
      7: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom), $urandom};
      default: return 64'(signed'(int'($urandom))) << $urandom_range(0, 24);
    endcase
  endfunction

  task automatic push(logic [63:0] v, ipa_pkg::op_t op);
    ipa_pkg::in_item_t it;
    it.operand = v;
    it.opcode = 3'(op);
    item_q.insert(item_q.size(), it);
  endtask

  initial begin
    int len;
    ipa_pkg::in_item_t it;
    // directed: extremes, every operator, precedence, zero divide, unused codes
    push(64'h7FFF_FFFF_FFFF_FFFF, ipa_pkg::OP_ADD);
    push(64'h7FFF_FFFF_FFFF_FFFF, ipa_pkg::OP_END);
    push(64'h8000_0000_0000_0000, ipa_pkg::OP_SUB); push(64'h1_0000_0000, ipa_pkg::OP_END);
    push(64'h5_0000_0000, ipa_pkg::OP_END);                        // lone operand
    push(64'hA_0000_0000, ipa_pkg::OP_SUB); push(64'h2_0000_0000, ipa_pkg::OP_MUL);
    push(64'h3_0000_0000, ipa_pkg::OP_END);                        // a-b*c
    push(64'h7_0000_0000, ipa_pkg::OP_DIV); push(64'd0, ipa_pkg::OP_ADD);
    push(64'h1_0000_0000, ipa_pkg::OP_END);                        // divide by zero
    push(64'h7_0000_0000, ipa_pkg::OP_MOD); push(64'd0, ipa_pkg::OP_END);
    push(64'hFFFF_FFF9_0000_0000, ipa_pkg::OP_MOD); push(64'h2_0000_0000, ipa_pkg::OP_END);
    push(64'h7FFF_FFFF_FFFF_FFFF, ipa_pkg::OP_MUL);
    push(64'h7FFF_FFFF_FFFF_FFFF, ipa_pkg::OP_END);
    push(64'h8000_0000_0000_0000, ipa_pkg::OP_DIV); push(64'd1, ipa_pkg::OP_END);
    it.operand = '1; it.opcode = 3'd6; item_q.insert(item_q.size(), it);
    it.opcode = 3'd7; item_q.insert(item_q.size(), it);
    push(64'h1_0000_0000, ipa_pkg::OP_ADD); push(64'h2_0000_0000, ipa_pkg::OP_DIV);
    push(64'h4_0000_0000, ipa_pkg::OP_END);
    // random expressions, mostly well formed
    while (item_q.size() < 875) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 30) == 0) begin
          it.operand = rand_operand(); it.opcode = 3'($urandom_range(6, 7));
          item_q.insert(item_q.size(), it);
        end
        push(rand_operand(), ipa_pkg::op_t'($urandom_range(0, 4)));
      end
      push(rand_operand(), ipa_pkg::OP_END);
    end
  end

  // ---------------- reset ----------------
  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------- driver ----------------
  int gap_in;
  initial begin
    in_valid = 1'b0; in_data = '0; gap_in = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_item(in_data);
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_in > 0) begin
          gap_in <= gap_in - 1;
          in_valid <= 1'b0;
        end else if (item_q.size() > 0) begin
          in_data <= item_q.pop_front();
          in_valid <= 1'b1;
          gap_in <= ($urandom_range(0, 3) == 0) ?
                    (($urandom_range(0, 15) == 0) ? $urandom_range(20, 150)
                                                  : $urandom_range(1, 3)) : 0;
        end else begin
          in_valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // ---------------- monitor / result sink ----------------
  int hold_cnt, gap_out;
  bit long_hold_done;
  initial begin
    out_ready = 1'b0; hold_cnt = 0; gap_out = 0; long_hold_done = 0;
    n_fail = 0; n_sent = 0; n_results = 0; n_zdiv = 0; stim_done = 0; idle_cnt = 0;
    clear_expr();
  end

  always @(posedge clk) begin
    ipa_pkg::out_item_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (out_data.zero_divide) n_zdiv++;
        if (result_q.size() == 0) begin
          $error("unexpected result transfer: result=%h", out_data.result);
          n_fail++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_data.result !== exp_r.result) begin
            $error("result mismatch: expected %h actual %h", exp_r.result, out_data.result);
            n_fail++;
          end
          if (out_data.zero_divide !== exp_r.zero_divide) begin
            $error("zero_divide mismatch: expected %b actual %b",
                   exp_r.zero_divide, out_data.zero_divide);
            n_fail++;
          end
        end
      end
      // one long hold-off after twenty results, so the block backs up
      if (!long_hold_done && n_results == 20) begin
        long_hold_done <= 1'b1;
        hold_cnt <= 3000;
        out_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        gap_out <= ($urandom_range(0, 10) == 0) ? $urandom_range(20, 200)
                                                : $urandom_range(1, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------- watchdog and end of run ----------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
  end

  initial begin
    wait (stim_done && result_q.size() == 0);
    repeat (500) @(posedge clk);
    $display("Sent %0d items, checked %0d expression results (%0d with zero divide).",
             n_sent, n_results, n_zdiv);
    if (n_fail == 0 && result_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    wait (idle_cnt >= WDOG_LIMIT);
    $display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
